// File: rtl/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// Types, codes and helpers shared by the gzip header/trailer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gzhp_pkg;

  // action codes carried in the input beat
  localparam logic [1:0] ACT_HEADER  = 2'd0;
  localparam logic [1:0] ACT_TRAILER = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;

  localparam logic [7:0]  ID_FIRST       = 8'h1f;
  localparam logic [7:0]  ID_SECOND      = 8'h8b;
  localparam logic [7:0]  METHOD_DEFLATE = 8'd8;
  localparam logic [15:0] FIXED_LEN      = 16'd10;
  localparam logic [15:0] EXTRA_CODE_POS = 16'd10;
  localparam logic [16:0] LEN_MAX        = 17'h1ffff;

  // bit positions in the FLG byte
  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_EXTRA   = 3'd2,
    PH_NAME    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_HCRC    = 3'd5,
    PH_DONE    = 3'd6,
    PH_REJECT  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] chunk_index;
  } in_beat_t;

  typedef struct packed {
    logic        header_done;
    logic        magic_ok;
    logic        deflate_ok;
    logic [16:0] header_length;
    logic [7:0]  extra_flags_value;
    logic [15:0] subfield_version;
    logic [15:0] chunk_length;
    logic [15:0] chunk_count;
    logic [15:0] chunk_code;
    logic [31:0] trailer_crc;
    logic [31:0] trailer_size;
    logic        error_flag;
  } out_beat_t;

  // parser state as seen after one beat, everything but the lookup result
  typedef struct packed {
    logic        header_done;
    logic        magic_ok;
    logic        deflate_ok;
    logic [16:0] header_length;
    logic [7:0]  extra_flags_value;
    logic [15:0] subfield_version;
    logic [15:0] chunk_length;
    logic [15:0] chunk_count;
    logic [31:0] trailer_crc;
    logic [31:0] trailer_size;
  } view_t;

  // next optional header section after cur, given the FLG byte
  function automatic phase_t phase_after(phase_t cur, logic [7:0] flags);
    phase_t ph;
    if (cur < PH_XLEN && flags[FLG_EXTRA]) begin
      ph = PH_XLEN;
    end else if (cur < PH_NAME && flags[FLG_NAME]) begin
      ph = PH_NAME;
    end else if (cur < PH_COMMENT && flags[FLG_COMMENT]) begin
      ph = PH_COMMENT;
    end else if (cur < PH_HCRC && flags[FLG_HCRC]) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gzhp_ram.sv
// ----------------------------------------------------------------------------
// gzhp_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gzhp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gzhp_parse.sv
// ----------------------------------------------------------------------------
// gzhp_parse
// Header phase machine, held header fields, trailer window and chunk store
// write/read address generation. State updates on each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gzhp_parse #(
  parameter int MAX_CHUNKS = 4096,
  parameter int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  parameter int CW = $clog2(MAX_CHUNKS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire gzhp_pkg::in_beat_t beat,
  output gzhp_pkg::view_t        view,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [15:0]            wr_data,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  output logic                   lookup_err
);

  import gzhp_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [15:0]   xlen_r, xlen_nxt;
  logic [16:0]   len_r, len_nxt;
  logic          magic_r, magic_nxt;
  logic          defl_r, defl_nxt;
  logic          done_r, done_nxt;
  logic [7:0]    xfl_r, xfl_nxt;
  logic [15:0]   ver_r, ver_nxt;
  logic [15:0]   clen_r, clen_nxt;
  logic [15:0]   ccnt_r, ccnt_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic [7:0]    lowb_r, lowb_nxt;
  logic [63:0]   trail_r, trail_nxt;
  logic          code_wr;
  logic [16:0]   pos_inc;
  logic [16:0]   idx_ext;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    flags_nxt  = flags_r;
    xlen_nxt   = xlen_r;
    len_nxt    = len_r;
    magic_nxt  = magic_r;
    defl_nxt   = defl_r;
    done_nxt   = done_r;
    xfl_nxt    = xfl_r;
    ver_nxt    = ver_r;
    clen_nxt   = clen_r;
    ccnt_nxt   = ccnt_r;
    stored_nxt = stored_r;
    lowb_nxt   = lowb_r;
    trail_nxt  = trail_r;
    code_wr    = 1'b0;
    pos_inc    = 17'd0;

    if (en && beat.action == ACT_HEADER) begin
      // restart clears the header side before the byte is taken
      if (beat.first_byte) begin
        phase_nxt  = PH_FIXED;
        pos_nxt    = '0;
        flags_nxt  = '0;
        xlen_nxt   = '0;
        len_nxt    = '0;
        magic_nxt  = 1'b0;
        defl_nxt   = 1'b0;
        done_nxt   = 1'b0;
        xfl_nxt    = '0;
        ver_nxt    = '0;
        clen_nxt   = '0;
        ccnt_nxt   = '0;
        stored_nxt = '0;
        lowb_nxt   = '0;
      end
      pos_inc = {1'b0, pos_nxt} + 17'd1;
      if (phase_nxt != PH_DONE && phase_nxt != PH_REJECT && len_nxt < LEN_MAX) begin
        len_nxt = len_nxt + 17'd1;
      end
      unique case (phase_nxt)
        PH_FIXED: begin
          if (pos_nxt == 16'd0 && beat.data_byte != ID_FIRST) begin
            phase_nxt = PH_REJECT;
            pos_nxt   = '0;
          end else if (pos_nxt == 16'd1 && beat.data_byte != ID_SECOND) begin
            phase_nxt = PH_REJECT;
            pos_nxt   = '0;
          end else begin
            if (pos_nxt == 16'd1) begin
              magic_nxt = 1'b1;
            end
            if (pos_nxt == 16'd2 && beat.data_byte == METHOD_DEFLATE) begin
              defl_nxt = 1'b1;
            end
            if (pos_nxt == 16'd3) begin
              flags_nxt = beat.data_byte;
            end
            if (pos_nxt == 16'd8) begin
              xfl_nxt = beat.data_byte;
            end
            if (pos_inc >= {1'b0, FIXED_LEN}) begin
              phase_nxt = phase_after(PH_FIXED, flags_nxt);
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_inc[15:0];
            end
          end
        end
        PH_XLEN: begin
          if (pos_nxt == 16'd0) begin
            xlen_nxt = {8'd0, beat.data_byte};
          end else begin
            xlen_nxt = {beat.data_byte, xlen_nxt[7:0]};
          end
          if (pos_inc >= 17'd2) begin
            phase_nxt = (xlen_nxt == 16'd0) ? phase_after(PH_EXTRA, flags_nxt) : PH_EXTRA;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_EXTRA: begin
          case (pos_nxt)
            16'd4:   ver_nxt  = {8'd0, beat.data_byte};
            16'd5:   ver_nxt  = {beat.data_byte, ver_nxt[7:0]};
            16'd6:   clen_nxt = {8'd0, beat.data_byte};
            16'd7:   clen_nxt = {beat.data_byte, clen_nxt[7:0]};
            16'd8:   ccnt_nxt = {8'd0, beat.data_byte};
            16'd9:   ccnt_nxt = {beat.data_byte, ccnt_nxt[7:0]};
            default: begin
              if (pos_nxt >= EXTRA_CODE_POS) begin
                if (!pos_nxt[0]) begin
                  lowb_nxt = beat.data_byte;
                end else if (32'(stored_nxt) < MAX_CHUNKS) begin
                  code_wr = 1'b1;
                end
              end
            end
          endcase
          if (pos_inc >= {1'b0, xlen_nxt}) begin
            phase_nxt = phase_after(PH_EXTRA, flags_nxt);
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_NAME, PH_COMMENT: begin
          if (beat.data_byte == 8'd0) begin
            phase_nxt = phase_after(phase_nxt, flags_nxt);
            pos_nxt   = '0;
          end
        end
        PH_HCRC: begin
          if (pos_inc >= 17'd2) begin
            phase_nxt = PH_DONE;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_DONE, PH_REJECT: begin
          // header already finished or rejected
        end
        default: begin
        end
      endcase
      if (phase_nxt == PH_DONE) begin
        done_nxt = 1'b1;
      end
      if (code_wr) begin
        stored_nxt = stored_nxt + CW'(1);
      end
    end else if (en && beat.action == ACT_TRAILER) begin
      trail_nxt = {beat.data_byte, (beat.first_byte ? 56'd0 : trail_r[63:8])};
    end
  end

  // outputs
  always_comb begin
    view.header_done       = done_nxt;
    view.magic_ok          = magic_nxt;
    view.deflate_ok        = defl_nxt;
    view.header_length     = (phase_nxt == PH_REJECT) ? 17'd0 : len_nxt;
    view.extra_flags_value = xfl_nxt;
    view.subfield_version  = ver_nxt;
    view.chunk_length      = clen_nxt;
    view.chunk_count       = ccnt_nxt;
    view.trailer_crc       = trail_nxt[31:0];
    view.trailer_size      = trail_nxt[63:32];

    // a code write never coincides with a restart, so stored_r is the slot
    wr_en   = code_wr;
    wr_addr = stored_r[AW-1:0];
    wr_data = {beat.data_byte, lowb_r};

    idx_ext    = {1'b0, beat.chunk_index};
    lookup_err = (beat.chunk_index == 16'd0) || (idx_ext > 17'(stored_r));
    rd_en      = en && beat.action == ACT_LOOKUP && !lookup_err;
    rd_addr    = AW'(beat.chunk_index - 16'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIXED;
      pos_r    <= '0;
      flags_r  <= '0;
      xlen_r   <= '0;
      len_r    <= '0;
      magic_r  <= 1'b0;
      defl_r   <= 1'b0;
      done_r   <= 1'b0;
      xfl_r    <= '0;
      ver_r    <= '0;
      clen_r   <= '0;
      ccnt_r   <= '0;
      stored_r <= '0;
      lowb_r   <= '0;
      trail_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      flags_r  <= flags_nxt;
      xlen_r   <= xlen_nxt;
      len_r    <= len_nxt;
      magic_r  <= magic_nxt;
      defl_r   <= defl_nxt;
      done_r   <= done_nxt;
      xfl_r    <= xfl_nxt;
      ver_r    <= ver_nxt;
      clen_r   <= clen_nxt;
      ccnt_r   <= ccnt_nxt;
      stored_r <= stored_nxt;
      lowb_r   <= lowb_nxt;
      trail_r  <= trail_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gzip_header_trailer_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_trailer_parser
// gzip header/trailer parser with a dictzip chunk code table and lookup.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall is low and returns one result beat
// per input beat, in order, through the middle stage and the output register.
// Parser state updates at the accepting edge; a lookup reads the chunk store on
// that same edge through its single registered read port, and the read data
// joins the result in the stage that follows. The store holds up to MAX_CHUNKS
// codes and needs no clearing after reset, so beats are taken right away.
`default_nettype none

module gzip_header_trailer_parser #(
  parameter int MAX_CHUNKS = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gzhp_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gzhp_pkg::out_beat_t      out_beat
);

  import gzhp_pkg::*;

  localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  view_t           view;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [15:0]     wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            lookup_err;
  logic [15:0]     ram_q;

  logic            in_acc;
  logic            out_take;
  logic            s1_move;
  logic            s1_valid_r, s1_valid_nxt;
  view_t           s1_view_r;
  logic            s1_hit_r;
  logic            s1_err_r;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_beat_r;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_take;
  assign in_stall = s1_valid_r && !out_take;
  assign in_acc   = in_valid && !in_stall;

  gzhp_parse #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .AW         (AW),
    .CW         (CW)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_acc),
    .beat       (in_beat),
    .view       (view),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .lookup_err (lookup_err)
  );

  gzhp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CHUNKS),
    .AW    (AW)
  ) u_code_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !out_take);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_view_r <= view;
      s1_hit_r  <= rd_en;
      s1_err_r  <= in_beat.action == ACT_LOOKUP && lookup_err;
    end
  end

  // chunk code joins the beat once the store read data is out
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_beat_r.header_done       <= s1_view_r.header_done;
      out_beat_r.magic_ok          <= s1_view_r.magic_ok;
      out_beat_r.deflate_ok        <= s1_view_r.deflate_ok;
      out_beat_r.header_length     <= s1_view_r.header_length;
      out_beat_r.extra_flags_value <= s1_view_r.extra_flags_value;
      out_beat_r.subfield_version  <= s1_view_r.subfield_version;
      out_beat_r.chunk_length      <= s1_view_r.chunk_length;
      out_beat_r.chunk_count       <= s1_view_r.chunk_count;
      out_beat_r.chunk_code        <= s1_hit_r ? ram_q : 16'd0;
      out_beat_r.trailer_crc       <= s1_view_r.trailer_crc;
      out_beat_r.trailer_size      <= s1_view_r.trailer_size;
      out_beat_r.error_flag        <= s1_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  // store read data must hold while the middle stage waits
  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_hit_r && !out_take |=> $stable(ram_q))
    else $error("chunk store read data changed under a held beat");

  a_err_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_beat_r.error_flag |-> out_beat_r.chunk_code == 16'd0)
    else $error("invalid lookup returned a nonzero code");

  a_done_magic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_beat_r.header_done |-> out_beat_r.magic_ok)
    else $error("header done without matching identification bytes");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_take |-> !in_acc)
    else $error("beat accepted while middle stage blocked");
`endif

endmodule

`default_nettype wire
